FILE: rtl/dltr_pkg.sv
package dltr_pkg;

	// layer geometry and number formats
	localparam int MAX_IN    = 64;
	localparam int MAX_OUT   = 64;
	localparam int MAX_BATCH = 16;
	localparam int DATA_BITS = 16;
	localparam int IDX_W     = 6;
	localparam int BROW_W    = 4;
	localparam int CNT_W     = 7;
	localparam int GRAD_W    = 32;
	localparam int LR_W      = 16;
	localparam int OPA_W     = LR_W + 1;
	localparam int PROD_W    = OPA_W + GRAD_W;
	localparam int ACC_W     = 40;
	localparam int W_ADDR_W  = 2 * IDX_W;
	localparam int X_ADDR_W  = BROW_W + IDX_W;
	localparam int W_DEPTH   = MAX_IN * MAX_OUT;
	localparam int X_DEPTH   = MAX_BATCH * MAX_IN;

	// command codes
	localparam logic [2:0] CMD_LOAD_W = 3'd0;
	localparam logic [2:0] CMD_LOAD_B = 3'd1;
	localparam logic [2:0] CMD_FWD    = 3'd2;
	localparam logic [2:0] CMD_BWD    = 3'd3;
	localparam logic [2:0] CMD_UPDATE = 3'd4;
	localparam logic [2:0] CMD_READ_W = 3'd5;
	localparam logic [2:0] CMD_READ_B = 3'd6;

	// result kinds
	localparam logic [2:0] KIND_ACT   = 3'd0;
	localparam logic [2:0] KIND_GRADX = 3'd1;
	localparam logic [2:0] KIND_WREAD = 3'd2;
	localparam logic [2:0] KIND_BREAD = 3'd3;
	localparam logic [2:0] KIND_ACK   = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_ERR = 2'd1;
	localparam logic [1:0] STAT_SAT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_IN_COUNT   = 2'd0;
	localparam logic [1:0] REG_OUT_COUNT  = 2'd1;
	localparam logic [1:0] REG_LEARN_RATE = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		M_FWD,
		M_GRADX,
		M_WGRAD,
		M_BGRAD,
		M_UPDW,
		M_UPDB
	} mode_t;

	typedef struct packed {
		logic [2:0]               cmd;
		logic [BROW_W-1:0]        batch_row;
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic signed [DATA_BITS-1:0] value;
	} in_t;

	typedef struct packed {
		logic [2:0]               kind;
		logic [IDX_W-1:0]         index;
		logic signed [DATA_BITS-1:0] result_value;
		logic                     last;
		logic [1:0]               status;
	} out_t;

	// control that travels with one memory access through the mac
	typedef struct packed {
		logic  valid;
		logic  first;
		logic  b_zero;
		mode_t mode;
	} mac_ctl_t;

endpackage

FILE: rtl/dense_layer_train_engine_core.sv
// Dense layer training engine, Q4.12 data, Q16.16 gradients, Q0.16 learning rate.
// Weights, gradients and saved inputs live in synchronous memories with separate read and
// write addresses; one multiply-accumulate pipeline walks them, one access per cycle
// to the weight and gradient memories while a pass issues. After reset the gradient
// memories are swept to zero, during which no input transaction is taken;
// configuration writes are taken at any time.
module dense_layer_train_engine_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dltr_pkg::in_t    in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output dltr_pkg::out_t   out_item,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import dltr_pkg::*;

	// memories
	logic signed [DATA_BITS-1:0] w_mem  [W_DEPTH];
	logic signed [DATA_BITS-1:0] b_mem  [MAX_OUT];
	logic signed [GRAD_W-1:0]    wg_mem [W_DEPTH];
	logic signed [GRAD_W-1:0]    bg_mem [MAX_OUT];
	logic signed [DATA_BITS-1:0] x_mem  [X_DEPTH];
	logic signed [DATA_BITS-1:0] gr_mem [MAX_OUT];

	logic signed [DATA_BITS-1:0] w_rd, b_rd, x_rd, gr_rd;
	logic signed [GRAD_W-1:0]    wg_rd, bg_rd;
	logic [W_ADDR_W-1:0]         w_ra, wg_ra, wa_s0, wa_s1, wa_s2;
	logic [IDX_W-1:0]            b_ra, bg_ra;

	state_t state_q, state_n;
	mode_t  mode_q;
	logic [CNT_W-1:0]    in_cnt_q, out_cnt_q, cfg_cnt;
	logic [LR_W-1:0]     lr_q;
	logic [IDX_W-1:0]    o_q, k_q, c_q;
	logic [BROW_W-1:0]   b_q;
	logic [2:0]          cmd_q;
	logic signed [DATA_BITS-1:0] v_q;
	logic [W_ADDR_W-1:0] clr_q;
	logic                res_vec_q, upd_sat_q;
	out_t                res_q, out_q;
	logic                out_valid_q;

	mac_ctl_t ctl_s0, ctl_s1, ctl_s2;
	logic signed [OPA_W-1:0]     a_s1;
	logic signed [GRAD_W-1:0]    bop_s1, old_s1, wr_data;
	logic                        wr_sat, res_sat;
	logic signed [DATA_BITS-1:0] res_value;

	logic acc_in, r_bad, c_bad, b_bad, fwd_end, emit_mode;
	logic [CNT_W-1:0] on_cnt, kn_cnt;
	logic k_last, o_last, c_last, drain_done, out_free, clr_done, issue;

	// configuration registers, counts clamped to 1..64
	always_comb begin
		cfg_cnt = cfg_data[CNT_W-1:0];
		if (cfg_cnt == '0) begin
			cfg_cnt = CNT_W'(1);
		end else if (cfg_cnt > CNT_W'(MAX_IN)) begin
			cfg_cnt = CNT_W'(MAX_IN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= CNT_W'(MAX_IN);
			out_cnt_q <= CNT_W'(MAX_OUT);
			lr_q      <= LR_W'(655);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IN_COUNT:   in_cnt_q  <= cfg_cnt;
				REG_OUT_COUNT:  out_cnt_q <= cfg_cnt;
				REG_LEARN_RATE: lr_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// input decode
	assign acc_in  = in_valid && in_ready;
	assign r_bad   = {1'b0, in_item.row_index} >= in_cnt_q;
	assign c_bad   = {1'b0, in_item.col_index} >= out_cnt_q;
	assign b_bad   = {1'b0, in_item.batch_row} >= (BROW_W+1)'(MAX_BATCH);
	assign fwd_end = {1'b0, in_item.row_index} == in_cnt_q - CNT_W'(1);

	// loop bounds of the current pass
	always_comb begin
		case (mode_q)
			M_FWD:   begin on_cnt = out_cnt_q;    kn_cnt = in_cnt_q;  end
			M_GRADX: begin on_cnt = in_cnt_q;     kn_cnt = out_cnt_q; end
			M_WGRAD: begin on_cnt = CNT_W'(1);    kn_cnt = in_cnt_q;  end
			M_BGRAD: begin on_cnt = CNT_W'(1);    kn_cnt = CNT_W'(1); end
			M_UPDW:  begin on_cnt = in_cnt_q;     kn_cnt = out_cnt_q; end
			default: begin on_cnt = CNT_W'(1);    kn_cnt = out_cnt_q; end
		endcase
	end

	assign emit_mode  = (mode_q == M_FWD) || (mode_q == M_GRADX);
	assign k_last     = {1'b0, k_q} == kn_cnt - CNT_W'(1);
	assign o_last     = {1'b0, o_q} == on_cnt - CNT_W'(1);
	assign c_last     = {1'b0, c_q} == out_cnt_q - CNT_W'(1);
	assign drain_done = !ctl_s1.valid && !ctl_s2.valid;
	assign out_free   = !out_valid_q || out_ready;
	assign clr_done   = clr_q == '1;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_done) state_n = ST_IDLE;
			ST_IDLE: begin
				if (acc_in) begin
					case (in_item.cmd)
						CMD_FWD:    state_n = (b_bad || r_bad) ? ST_EMIT :
						                      (fwd_end ? ST_ISSUE : ST_IDLE);
						CMD_BWD:    state_n = (b_bad || c_bad) ? ST_EMIT : ST_ISSUE;
						CMD_UPDATE: state_n = ST_ISSUE;
						CMD_READ_W: state_n = (r_bad || c_bad) ? ST_EMIT : ST_READ;
						CMD_READ_B: state_n = c_bad ? ST_EMIT : ST_READ;
						default:    state_n = ST_EMIT;
					endcase
				end
			end
			ST_READ:  state_n = ST_EMIT;
			ST_ISSUE: if (k_last && (emit_mode || o_last)) state_n = ST_DRAIN;
			ST_DRAIN: begin
				if (drain_done) begin
					case (mode_q)
						M_FWD, M_GRADX, M_UPDB: state_n = ST_EMIT;
						M_BGRAD:                state_n = c_last ? ST_ISSUE : ST_IDLE;
						default:                state_n = ST_ISSUE;
					endcase
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_n = (res_vec_q && !res_q.last) ? ST_ISSUE : ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		issue    = (state_q == ST_ISSUE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	// sequencer counters and pass selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_FWD;
			o_q       <= '0;
			k_q       <= '0;
			clr_q     <= '0;
			res_vec_q <= 1'b0;
			upd_sat_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + W_ADDR_W'(1);
			end
			if (ctl_s2.valid && (ctl_s2.mode == M_UPDW || ctl_s2.mode == M_UPDB) && wr_sat) begin
				upd_sat_q <= 1'b1;
			end
			if (acc_in) begin
				o_q       <= '0;
				k_q       <= '0;
				upd_sat_q <= 1'b0;
				res_vec_q <= 1'b0;
				case (in_item.cmd)
					CMD_FWD:    begin mode_q <= M_FWD;   res_vec_q <= 1'b1; end
					CMD_BWD:    mode_q <= M_WGRAD;
					CMD_UPDATE: mode_q <= M_UPDW;
					default: ;
				endcase
			end
			if (issue) begin
				if (k_last) begin
					k_q <= '0;
					if (!emit_mode && !o_last) begin
						o_q <= o_q + IDX_W'(1);
					end
				end else begin
					k_q <= k_q + IDX_W'(1);
				end
			end
			if (state_q == ST_DRAIN && drain_done) begin
				case (mode_q)
					M_WGRAD: begin mode_q <= M_BGRAD; o_q <= '0; k_q <= '0; end
					M_BGRAD: begin
						mode_q <= M_GRADX; o_q <= '0; k_q <= '0; res_vec_q <= 1'b1;
					end
					M_UPDW:  begin mode_q <= M_UPDB;  o_q <= '0; k_q <= '0; end
					M_UPDB:  res_vec_q <= 1'b0;
					default: ;
				endcase
			end
			if (state_q == ST_EMIT && out_free && res_vec_q && !res_q.last) begin
				o_q <= o_q + IDX_W'(1);
				k_q <= '0;
			end
		end
	end

	// transaction fields and pending result
	always_ff @(posedge clk) begin
		if (acc_in) begin
			cmd_q               <= in_item.cmd;
			b_q                 <= in_item.batch_row;
			c_q                 <= in_item.col_index;
			v_q                 <= in_item.value;
			res_q.kind          <= KIND_ACK;
			res_q.index         <= '0;
			res_q.result_value  <= '0;
			res_q.last          <= 1'b1;
			res_q.status        <= STAT_OK;
			case (in_item.cmd)
				CMD_LOAD_W: if (r_bad || c_bad) res_q.status <= STAT_ERR;
				CMD_LOAD_B: if (c_bad) res_q.status <= STAT_ERR;
				CMD_FWD:    if (b_bad || r_bad) res_q.status <= STAT_ERR;
				CMD_BWD:    if (b_bad || c_bad) res_q.status <= STAT_ERR;
				CMD_UPDATE: ;
				CMD_READ_W: begin
					res_q.kind  <= KIND_WREAD;
					res_q.index <= in_item.col_index;
					if (r_bad || c_bad) res_q.status <= STAT_ERR;
				end
				CMD_READ_B: begin
					res_q.kind  <= KIND_BREAD;
					res_q.index <= in_item.col_index;
					if (c_bad) res_q.status <= STAT_ERR;
				end
				default:    res_q.status <= STAT_ERR;
			endcase
		end
		if (state_q == ST_READ) begin
			res_q.result_value <= (cmd_q == CMD_READ_W) ? w_rd : b_rd;
		end
		if (state_q == ST_DRAIN && drain_done) begin
			if (emit_mode) begin
				res_q.kind         <= (mode_q == M_FWD) ? KIND_ACT : KIND_GRADX;
				res_q.index        <= o_q;
				res_q.result_value <= res_value;
				res_q.last         <= o_last;
				res_q.status       <= res_sat ? STAT_SAT : STAT_OK;
			end else if (mode_q == M_UPDB) begin
				res_q.kind         <= KIND_ACK;
				res_q.index        <= '0;
				res_q.result_value <= '0;
				res_q.last         <= 1'b1;
				res_q.status       <= upd_sat_q ? STAT_SAT : STAT_OK;
			end
		end
	end

	// memory addressing for the current pass
	always_comb begin
		if (state_q == ST_IDLE) begin
			w_ra = {in_item.row_index, in_item.col_index};
			b_ra = in_item.col_index;
		end else if (mode_q == M_FWD) begin
			w_ra = {k_q, o_q};
			b_ra = o_q;
		end else begin
			w_ra = {o_q, k_q};
			b_ra = k_q;
		end
		wg_ra = (mode_q == M_WGRAD) ? {k_q, c_q} : {o_q, k_q};
		bg_ra = (mode_q == M_BGRAD) ? c_q : k_q;
		case (mode_q)
			M_WGRAD: wa_s0 = {k_q, c_q};
			M_BGRAD: wa_s0 = W_ADDR_W'(c_q);
			M_UPDB:  wa_s0 = W_ADDR_W'(k_q);
			default: wa_s0 = {o_q, k_q};
		endcase
		ctl_s0.valid  = issue;
		ctl_s0.first  = (k_q == '0);
		ctl_s0.b_zero = (b_q == '0);
		ctl_s0.mode   = mode_q;
	end

	// weight and bias memories
	always_ff @(posedge clk) begin
		if (acc_in && in_item.cmd == CMD_LOAD_W && !r_bad && !c_bad) begin
			w_mem[{in_item.row_index, in_item.col_index}] <= in_item.value;
		end else if (ctl_s2.valid && ctl_s2.mode == M_UPDW) begin
			w_mem[wa_s2] <= wr_data[DATA_BITS-1:0];
		end
		w_rd <= w_mem[w_ra];
	end

	always_ff @(posedge clk) begin
		if (acc_in && in_item.cmd == CMD_LOAD_B && !c_bad) begin
			b_mem[in_item.col_index] <= in_item.value;
		end else if (ctl_s2.valid && ctl_s2.mode == M_UPDB) begin
			b_mem[wa_s2[IDX_W-1:0]] <= wr_data[DATA_BITS-1:0];
		end
		b_rd <= b_mem[b_ra];
	end

	// gradient memories, swept to zero after reset
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			wg_mem[clr_q] <= '0;
		end else if (ctl_s2.valid && ctl_s2.mode == M_WGRAD) begin
			wg_mem[wa_s2] <= wr_data;
		end
		wg_rd <= wg_mem[wg_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			bg_mem[clr_q[IDX_W-1:0]] <= '0;
		end else if (ctl_s2.valid && ctl_s2.mode == M_BGRAD) begin
			bg_mem[wa_s2[IDX_W-1:0]] <= wr_data;
		end
		bg_rd <= bg_mem[bg_ra];
	end

	// saved inputs and gradient row
	always_ff @(posedge clk) begin
		if (acc_in && in_item.cmd == CMD_FWD && !b_bad && !r_bad) begin
			x_mem[{in_item.batch_row, in_item.row_index}] <= in_item.value;
		end
		x_rd <= x_mem[{b_q, k_q}];
	end

	always_ff @(posedge clk) begin
		if (acc_in && in_item.cmd == CMD_BWD && !b_bad && !c_bad) begin
			gr_mem[in_item.col_index] <= in_item.value;
		end
		gr_rd <= gr_mem[k_q];
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_s0;
		end
	end

	always_ff @(posedge clk) begin
		wa_s1 <= wa_s0;
		wa_s2 <= wa_s1;
	end

	// multiplier operands per pass
	always_comb begin
		case (ctl_s1.mode)
			M_FWD: begin
				a_s1 = OPA_W'(x_rd);  bop_s1 = GRAD_W'(w_rd);  old_s1 = GRAD_W'(b_rd);
			end
			M_GRADX: begin
				a_s1 = OPA_W'(gr_rd); bop_s1 = GRAD_W'(w_rd);  old_s1 = '0;
			end
			M_WGRAD: begin
				a_s1 = OPA_W'(x_rd);  bop_s1 = GRAD_W'(v_q);   old_s1 = wg_rd;
			end
			M_BGRAD: begin
				a_s1 = OPA_W'(v_q);   bop_s1 = GRAD_W'(16);    old_s1 = bg_rd;
			end
			M_UPDW: begin
				a_s1 = {1'b0, lr_q};  bop_s1 = wg_rd;          old_s1 = GRAD_W'(w_rd);
			end
			default: begin
				a_s1 = {1'b0, lr_q};  bop_s1 = bg_rd;          old_s1 = GRAD_W'(b_rd);
			end
		endcase
	end

	dltr_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.a_s1      (a_s1),
		.b_s1      (bop_s1),
		.old_s1    (old_s1),
		.ctl_s2    (ctl_s2),
		.wr_data   (wr_data),
		.wr_sat    (wr_sat),
		.res_value (res_value),
		.res_sat   (res_sat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	// pipeline traffic only while a pass runs
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.valid |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
		else $error("mac write outside a pass");

	// a result is only taken once the pipeline is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (!ctl_s1.valid && !ctl_s2.valid))
		else $error("emit with pipeline busy");

	// no transaction taken during the gradient clear sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_ready)
		else $error("input taken during clear");

	// counts stay within the clamp range
	assert property (@(posedge clk) disable iff (!arst_n)
		in_cnt_q != '0 && in_cnt_q <= CNT_W'(MAX_IN) &&
		out_cnt_q != '0 && out_cnt_q <= CNT_W'(MAX_OUT))
		else $error("count out of range");
`endif

endmodule

FILE: rtl/dltr_mac.sv
module dltr_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dltr_pkg::mac_ctl_t                    ctl_s1,
	input  logic signed [dltr_pkg::OPA_W-1:0]     a_s1,
	input  logic signed [dltr_pkg::GRAD_W-1:0]    b_s1,
	input  logic signed [dltr_pkg::GRAD_W-1:0]    old_s1,
	output dltr_pkg::mac_ctl_t                    ctl_s2,
	output logic signed [dltr_pkg::GRAD_W-1:0]    wr_data,
	output logic                                  wr_sat,
	output logic signed [dltr_pkg::DATA_BITS-1:0] res_value,
	output logic                                  res_sat
);
	import dltr_pkg::*;

	localparam int EXT_W = 50;
	localparam logic signed [EXT_W-1:0] D_HI = EXT_W'((64'sd1 <<< (DATA_BITS - 1)) - 1);
	localparam logic signed [EXT_W-1:0] D_LO = -D_HI - 1;
	localparam logic signed [EXT_W-1:0] G_HI = EXT_W'((64'sd1 <<< (GRAD_W - 1)) - 1);
	localparam logic signed [EXT_W-1:0] G_LO = -G_HI - 1;

	logic signed [PROD_W-1:0] p_s2;
	logic signed [GRAD_W-1:0] old_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_base;
	logic signed [ACC_W-1:0]  acc_sum;
	logic signed [EXT_W-1:0]  p_ext;
	logic signed [EXT_W-1:0]  old_ext;
	logic signed [EXT_W-1:0]  rb8;
	logic signed [EXT_W-1:0]  rb20;
	logic signed [EXT_W-1:0]  rb12;
	logic signed [EXT_W-1:0]  q_round;
	logic signed [EXT_W-1:0]  d_round;
	logic signed [EXT_W-1:0]  g_sum;
	logic signed [EXT_W-1:0]  u_diff;
	logic signed [EXT_W-1:0]  r_round;

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s2   <= a_s1 * b_s1;
		old_s2 <= old_s1;
	end

	// dot product accumulator
	always_ff @(posedge clk) begin
		if (ctl_s2.valid && (ctl_s2.mode == M_FWD || ctl_s2.mode == M_GRADX)) begin
			acc_q <= acc_sum;
		end
	end

	assign p_ext   = EXT_W'(p_s2);
	assign old_ext = EXT_W'(old_s2);
	assign rb8     = {{(EXT_W-1){1'b0}}, p_s2[7]};
	assign rb20    = {{(EXT_W-1){1'b0}}, p_s2[19]};
	assign rb12    = {{(EXT_W-1){1'b0}}, acc_q[11]};

	// accumulate, rounding to nearest with halves going up
	always_comb begin
		if (!ctl_s2.first) begin
			acc_base = acc_q;
		end else if (ctl_s2.mode == M_FWD) begin
			acc_base = ACC_W'(old_s2) <<< 12;
		end else begin
			acc_base = '0;
		end
		acc_sum = acc_base + ACC_W'(p_s2);
		q_round = (p_ext >>> 8) + rb8;
		d_round = (p_ext >>> 20) + rb20;
		r_round = EXT_W'(acc_q >>> 12) + rb12;
		u_diff  = old_ext - d_round;
		g_sum   = ctl_s2.b_zero ? p_ext - p_ext : old_ext;
		if (ctl_s2.mode == M_BGRAD) begin
			g_sum = g_sum + p_ext;
		end else begin
			g_sum = g_sum + q_round;
		end
	end

	// write-back value with saturation
	always_comb begin
		wr_sat  = 1'b0;
		wr_data = '0;
		if (ctl_s2.mode == M_WGRAD || ctl_s2.mode == M_BGRAD) begin
			if (g_sum > G_HI) begin
				wr_data = GRAD_W'(G_HI);
				wr_sat  = 1'b1;
			end else if (g_sum < G_LO) begin
				wr_data = GRAD_W'(G_LO);
				wr_sat  = 1'b1;
			end else begin
				wr_data = GRAD_W'(g_sum);
			end
		end else begin
			if (u_diff > D_HI) begin
				wr_data = GRAD_W'(D_HI);
				wr_sat  = 1'b1;
			end else if (u_diff < D_LO) begin
				wr_data = GRAD_W'(D_LO);
				wr_sat  = 1'b1;
			end else begin
				wr_data = GRAD_W'(u_diff);
			end
		end
	end

	// final vector element from the accumulator
	always_comb begin
		res_sat = 1'b0;
		if (r_round > D_HI) begin
			res_value = DATA_BITS'(D_HI);
			res_sat   = 1'b1;
		end else if (r_round < D_LO) begin
			res_value = DATA_BITS'(D_LO);
			res_sat   = 1'b1;
		end else begin
			res_value = DATA_BITS'(r_round);
		end
	end

endmodule
